[hw/rtl/bec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bec_pkg;

  // character codes
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_LX  = 8'h78;
  localparam logic [7:0] CH_UX  = 8'h58;

  // direction register values
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // default depth of the command queue
  localparam int QUEUE_DEPTH_DEF = 4;

  // input transaction
  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] data_out;
    logic       has_byte;
    logic       last_out;
    logic       bad_escape;
  } out_t;

  // kinds of command from front to back
  typedef enum logic [2:0] {
    K_NONE = 3'd0,  // no byte, bare end marker
    K_ONE  = 3'd1,  // one byte
    K_CRLF = 3'd2,  // CR then LF
    K_ESC  = 3'd3,  // backslash then the byte
    K_HEX  = 3'd4   // backslash 0 x and two hex digits of the byte
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } cmd_t;

  // lower-case hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else             r = 8'h57 + {4'd0, nib};
    return r;
  endfunction

  // hex digit value, top bit set when the byte is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    else                               r = 5'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bec_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bec_front
  import bec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic direction,
  input  wire in_t  in_payload,
  input  wire logic accept,
  output cmd_t      cmd,
  output logic      push
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_BSL  = 5'b00010,
    PH_ZERO = 5'b00100,
    PH_X    = 5'b01000,
    PH_HI   = 5'b10000
  } phase_t;

  phase_t     phase_r, phase_nxt, ph_step;
  logic [3:0] hi_r, hi_nxt;
  logic       err_r, err_nxt, err_step;
  logic [7:0] b;
  logic [4:0] hv;
  logic       last;

  assign b    = in_payload.data_in;
  assign last = in_payload.last_in;
  assign hv   = hex_val(b);

  // classify the byte and step the escape state
  always_comb begin
    cmd.kind = K_NONE;
    cmd.data = b;
    ph_step  = phase_r;
    hi_nxt   = hi_r;
    err_step = err_r;
    if (direction == DIR_ENCODE) begin
      if (b == CH_LF) begin
        cmd.kind = K_ESC;
        cmd.data = CH_N;
      end else if (b == CH_TAB) begin
        cmd.kind = K_ESC;
        cmd.data = CH_T;
      end else if (b[7]) begin
        cmd.kind = K_HEX;
      end else begin
        cmd.kind = K_ONE;
      end
    end else begin
      unique case (phase_r)
        PH_BSL: begin
          ph_step = PH_IDLE;
          if (b == CH_N) begin
            cmd.kind = K_CRLF;
          end else if (b == CH_R) begin
            cmd.kind = K_ONE;
            cmd.data = CH_CR;
          end else if (b == CH_T) begin
            cmd.kind = K_ONE;
            cmd.data = CH_TAB;
          end else if (b == CH_0) begin
            ph_step = PH_ZERO;
          end else begin
            cmd.kind = K_ONE;
          end
        end
        PH_ZERO: begin
          if (b == CH_LX || b == CH_UX) begin
            ph_step = PH_X;
          end else begin
            err_step = 1'b1;
            ph_step  = (b == CH_BSL) ? PH_BSL : PH_IDLE;
            cmd.kind = (b == CH_BSL) ? K_NONE : K_ONE;
          end
        end
        PH_X: begin
          if (hv[4]) begin
            hi_nxt  = hv[3:0];
            ph_step = PH_HI;
          end else begin
            err_step = 1'b1;
            ph_step  = (b == CH_BSL) ? PH_BSL : PH_IDLE;
            cmd.kind = (b == CH_BSL) ? K_NONE : K_ONE;
          end
        end
        PH_HI: begin
          if (hv[4]) begin
            cmd.kind = K_ONE;
            cmd.data = {hi_r, hv[3:0]};
            ph_step  = PH_IDLE;
          end else begin
            err_step = 1'b1;
            ph_step  = (b == CH_BSL) ? PH_BSL : PH_IDLE;
            cmd.kind = (b == CH_BSL) ? K_NONE : K_ONE;
          end
        end
        default: begin
          ph_step  = (b == CH_BSL) ? PH_BSL : PH_IDLE;
          cmd.kind = (b == CH_BSL) ? K_NONE : K_ONE;
        end
      endcase
    end
    // string ending inside an escape
    if (direction == DIR_DECODE && last && ph_step != PH_IDLE) err_step = 1'b1;
    cmd.last = last;
    cmd.bad  = (direction == DIR_DECODE) ? err_step : 1'b0;
    // state returns to idle after the final byte
    if (last) begin
      phase_nxt = PH_IDLE;
      err_nxt   = 1'b0;
    end else begin
      phase_nxt = ph_step;
      err_nxt   = err_step;
    end
  end

  assign push = accept && (cmd.kind != K_NONE || last);

  // escape state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hi_r    <= last ? 4'd0 : hi_nxt;
      err_r   <= err_nxt;
    end
  end

  // every final byte yields a command
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_payload.last_in |-> push)
    else $error("final byte gave no command");

  // state is clear after the final byte
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_payload.last_in |=> phase_r == PH_IDLE && !err_r)
    else $error("escape state not cleared at string end");

  // encode never flags an error
  a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    push && direction == DIR_ENCODE |-> !cmd.bad && cmd.kind != K_NONE)
    else $error("bad flag or empty command in encode");

endmodule

`default_nettype wire

[hw/rtl/bec_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bec_queue
  import bec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == FULL_CNT);
  assign head  = slot_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/bec_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bec_back
  import bec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t head,
  input  wire logic empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_payload
);

  logic [2:0] step_r, step_nxt, final_step;
  logic       load, at_end;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;
  logic [7:0] byte_sel;

  // number of result bytes less one for the head command
  always_comb begin
    case (head.kind)
      K_CRLF:  final_step = 3'd1;
      K_ESC:   final_step = 3'd1;
      K_HEX:   final_step = 3'd4;
      default: final_step = 3'd0;
    endcase
  end

  // byte for the current step
  always_comb begin
    byte_sel = 8'd0;
    unique case (head.kind)
      K_ONE:  byte_sel = head.data;
      K_CRLF: byte_sel = (step_r == 3'd0) ? CH_CR : CH_LF;
      K_ESC:  byte_sel = (step_r == 3'd0) ? CH_BSL : head.data;
      K_HEX: begin
        case (step_r)
          3'd0:    byte_sel = CH_BSL;
          3'd1:    byte_sel = CH_0;
          3'd2:    byte_sel = CH_LX;
          3'd3:    byte_sel = hex_char(head.data[7:4]);
          default: byte_sel = hex_char(head.data[3:0]);
        endcase
      end
      default: byte_sel = 8'd0;
    endcase
  end

  assign load   = !empty && (!out_valid_r || !out_stall);
  assign at_end = (step_r == final_step);
  assign pop    = load && at_end;

  // output register and step counter
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    step_nxt      = step_r;
    if (load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.data_out    = byte_sel;
      out_nxt.has_byte    = (head.kind != K_NONE);
      out_nxt.last_out    = head.last && at_end;
      out_nxt.bad_escape  = head.bad;
      step_nxt            = at_end ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // bare marker only ever closes a string
  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.has_byte |-> out_r.last_out)
    else $error("bare marker without end of string");

  // the step counter stays within a hex escape
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 3'd4)
    else $error("step counter out of range");

  // mid-command the head must still be there
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 3'd0 |-> !empty)
    else $error("queue head lost inside a command");

endmodule

`default_nettype wire

[hw/rtl/backslash_escape_codec_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_stall   | in_payload  : data_in, last_in
// result   | out_valid / out_stall | out_payload : data_out, has_byte,
//          |                       |               last_out, bad_escape
// config   | cfg_valid / cfg_ready | cfg_data    : direction
//
// A byte is classified in the cycle it is accepted and queued as at most one
// command. The expander gives one result per cycle unless out_stall holds it
// or the queue is empty: one for a plain byte, two for CR LF or a short
// escape, five for a hex escape; throughput is set by that unit.
// in_stall rises only when the command queue is full; reset is synchronous
// and clears the queue, the escape state and the direction register.

module backslash_escape_codec_top
  import bec_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_payload,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_payload,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  logic direction_r;
  logic accept, push, pop, empty, full;
  cmd_t cmd, head;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) direction_r <= DIR_ENCODE;
    else if (cfg_valid && cfg_ready) direction_r <= cfg_data;
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  bec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .direction  (direction_r),
    .in_payload (in_payload),
    .accept     (accept),
    .cmd        (cmd),
    .push       (push)
  );

  bec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  bec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire
